// File: rtl/point_move_to_target_macros.svh
// Assertion macros for the RTL of the point mover.
`ifndef POINT_MOVE_TO_TARGET_MACROS_SVH
`define POINT_MOVE_TO_TARGET_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PMT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("point mover check failed");

// Same check, with a message of its own.
`define PMT_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// File: rtl/pmt_pkg.sv
package pmt_pkg;

  localparam int unsigned FRAC_BITS = 16;

  typedef enum logic [2:0] {
    CmdSetPos     = 3'd0,
    CmdSetSpeed   = 3'd1,
    CmdStart      = 3'd2,
    CmdRetarget   = 3'd3,
    CmdRetTimed   = 3'd4,
    CmdStartTimed = 3'd5,
    CmdTick       = 3'd6
  } cmd_e;

  // An axis has passed its goal once position plus velocity reaches it.
  function automatic logic passed(logic signed [31:0] p, logic signed [31:0] v,
                                  logic signed [31:0] g);
    logic signed [32:0] s;
    logic signed [32:0] ge;
    s  = $signed({p[31], p}) + $signed({v[31], v});
    ge = $signed({g[31], g});
    if (v > 32'sd0) begin
      return s >= ge;
    end
    return s <= ge;
  endfunction

endpackage

// File: rtl/pmt_div.sv
module pmt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [63:0] quo_q;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    fits  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= divisor_i;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
      quo_q <= {quo_q[62:0], fits};
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/point_move_to_target.sv
// Point mover in signed fixed point. Every command returns one beat with
// the position and the motion flag. A tick uses the one shared 32x32
// multiplier once per axis. A set-up command runs the norm through a
// 32-step square root, then up to three 64-step divisions on the shared
// divider (timed speed, then each velocity component). The block takes a
// new command only after the result beat has left.
module point_move_to_target #(
  parameter int unsigned FracBits = pmt_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [31:0]        move_speed_i,
  input  logic signed [31:0] move_time_i,
  input  logic [31:0]        tick_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] cur_x_o,
  output logic signed [31:0] cur_y_o,
  output logic               moving_o
);

  `include "point_move_to_target_macros.svh"

  localparam logic [31:0] One = 32'(1) << FracBits;

  typedef enum logic [4:0] {
    SIdle, SAbs, SMulH, SMulV, SSum, SSqrt, STDiv, STWait, SVel,
    SVMul1, SVDiv1, SVWait1, SVDiv2, SVWait2,
    STick, STMulX, STAdvX, STAdvY, STSnap, SOut
  } state_e;

  state_e             state_q;
  logic signed [31:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q, vel_x_q, vel_y_q;
  logic [31:0]        speed_q, time_q, tick_q, d_q;
  logic               motion_q, mv_q, timed_q, sh_q, neg_x_q, neg_y_q;
  logic [30:0]        hs_q, vs_q;
  logic [63:0]        n_q, root_q, bit_q, mul_q;
  logic [31:0]        mul_a, mul_b;
  logic               div_start;
  logic [63:0]        div_dividend, div_quo;
  logic [31:0]        div_divisor;
  logic               div_done;
  logic signed [32:0] dx, dy;
  logic [31:0]        h, v;
  logic               sh;
  logic [63:0]        trial;
  logic [31:0]        vmag_x, vmag_y, spd_sat;

  function automatic logic signed [31:0] advance(logic signed [31:0] p,
                                                 logic signed [31:0] vel,
                                                 logic [63:0] mag);
    logic signed [65:0] delta;
    logic signed [65:0] r;
    delta = $signed({2'b00, mag >> FracBits});
    r = vel[31] ? ($signed(66'(p)) - delta) : ($signed(66'(p)) + delta);
    if (r > 66'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end
    if (r < -66'sh80000000) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  always_comb begin
    dx     = $signed({goal_x_q[31], goal_x_q}) - $signed({pos_x_q[31], pos_x_q});
    dy     = $signed({goal_y_q[31], goal_y_q}) - $signed({pos_y_q[31], pos_y_q});
    h      = dx[32] ? 32'(-dx) : dx[31:0];
    v      = dy[32] ? 32'(-dy) : dy[31:0];
    sh     = h[31] | v[31];
    trial  = root_q + bit_q;
    vmag_x = vel_x_q[31] ? 32'(-vel_x_q) : vel_x_q;
    vmag_y = vel_y_q[31] ? 32'(-vel_y_q) : vel_y_q;
    spd_sat = speed_q[31] ? 32'h7FFFFFFF : speed_q;
    case (state_q)
      SMulH, SMulV: begin
        mul_a = (state_q == SMulH) ? {1'b0, hs_q} : {1'b0, vs_q};
        mul_b = mul_a;
      end
      SVWait1, SVDiv2: begin
        mul_a = speed_q;
        mul_b = {1'b0, vs_q};
      end
      STMulX: begin
        mul_a = vmag_x;
        mul_b = tick_q;
      end
      STAdvX: begin
        mul_a = vmag_y;
        mul_b = tick_q;
      end
      default: begin
        mul_a = speed_q;
        mul_b = {1'b0, hs_q};
      end
    endcase
    div_start    = (state_q == STDiv) || (state_q == SVDiv1) || (state_q == SVDiv2);
    div_dividend = (state_q == STDiv) ?
                   (64'(sh_q ? {root_q[31:0], 1'b0} : {1'b0, root_q[31:0]}) << FracBits)
                   : mul_q;
    div_divisor  = (state_q == STDiv) ? time_q : d_q;
  end

  pmt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      speed_q  <= '0;
      motion_q <= 1'b0;
      mv_q     <= 1'b0;
      timed_q  <= 1'b0;
      time_q   <= '0;
      tick_q   <= '0;
      d_q      <= '0;
      sh_q     <= 1'b0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      hs_q     <= '0;
      vs_q     <= '0;
      n_q      <= '0;
      root_q   <= '0;
      bit_q    <= '0;
      mul_q    <= '0;
    end else begin
      mul_q <= 64'(mul_a) * 64'(mul_b);
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            tick_q  <= tick_time_i;
            timed_q <= 1'b0;
            state_q <= SAbs;
            case (pmt_pkg::cmd_e'(command_i))
              pmt_pkg::CmdSetPos: begin
                pos_x_q  <= pos_x_i;
                pos_y_q  <= pos_y_i;
                goal_x_q <= pos_x_i;
                goal_y_q <= pos_y_i;
                motion_q <= 1'b0;
                mv_q     <= 1'b0;
                state_q  <= SOut;
              end
              pmt_pkg::CmdSetSpeed: begin
                speed_q <= move_speed_i;
              end
              pmt_pkg::CmdStart: begin
                pos_x_q  <= pos_x_i;
                pos_y_q  <= pos_y_i;
                goal_x_q <= target_x_i;
                goal_y_q <= target_y_i;
                speed_q  <= move_speed_i;
                motion_q <= 1'b1;
              end
              pmt_pkg::CmdRetarget: begin
                if (move_speed_i != '0) begin
                  speed_q <= move_speed_i;
                end
                goal_x_q <= target_x_i;
                goal_y_q <= target_y_i;
                motion_q <= 1'b1;
              end
              pmt_pkg::CmdRetTimed: begin
                time_q   <= move_time_i[31] ? One : move_time_i;
                goal_x_q <= target_x_i;
                goal_y_q <= target_y_i;
                motion_q <= 1'b1;
                timed_q  <= 1'b1;
              end
              pmt_pkg::CmdStartTimed: begin
                pos_x_q  <= pos_x_i;
                pos_y_q  <= pos_y_i;
                goal_x_q <= target_x_i;
                goal_y_q <= target_y_i;
                motion_q <= 1'b1;
                time_q   <= move_time_i;
                if (move_time_i[31]) begin
                  speed_q <= One;
                end else begin
                  timed_q <= 1'b1;
                end
              end
              pmt_pkg::CmdTick: begin
                state_q <= STick;
              end
              default: begin
                mv_q    <= motion_q;
                state_q <= SOut;
              end
            endcase
          end
        end
        SAbs: begin
          sh_q    <= sh;
          hs_q    <= sh ? h[31:1] : h[30:0];
          vs_q    <= sh ? v[31:1] : v[30:0];
          neg_x_q <= dx[32];
          neg_y_q <= dy[32];
          state_q <= SMulH;
        end
        SMulH: begin
          state_q <= SMulV;
        end
        SMulV: begin
          n_q     <= mul_q;
          state_q <= SSum;
        end
        SSum: begin
          n_q     <= n_q + mul_q;
          root_q  <= '0;
          bit_q   <= 64'(1) << 62;
          state_q <= SSqrt;
        end
        SSqrt: begin
          if (n_q >= trial) begin
            n_q    <= n_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            state_q <= SVel;
            if (timed_q) begin
              state_q <= (time_q == '0) ? SVel : STDiv;
              if (time_q == '0) begin
                speed_q <= 32'hFFFFFFFF;
              end
            end
          end
        end
        STDiv: begin
          state_q <= STWait;
        end
        STWait: begin
          if (div_done) begin
            if (div_quo[63:32] != '0) begin
              speed_q <= 32'hFFFFFFFF;
            end else if (div_quo[31:0] < One) begin
              speed_q <= One;
            end else begin
              speed_q <= div_quo[31:0];
            end
            state_q <= SVel;
          end
        end
        SVel: begin
          d_q <= root_q[31:0];
          if (vs_q == '0) begin
            vel_x_q <= neg_x_q ? 32'(-spd_sat) : spd_sat;
            vel_y_q <= '0;
            mv_q    <= motion_q;
            state_q <= SOut;
          end else begin
            state_q <= SVMul1;
          end
        end
        SVMul1: begin
          state_q <= SVDiv1;
        end
        SVDiv1: begin
          state_q <= SVWait1;
        end
        SVWait1: begin
          if (div_done) begin
            vel_x_q <= neg_x_q ? 32'(-(div_quo[63:31] != '0 ? 32'h7FFFFFFF : div_quo[31:0]))
                               : (div_quo[63:31] != '0 ? 32'h7FFFFFFF : div_quo[31:0]);
            state_q <= SVDiv2;
          end
        end
        SVDiv2: begin
          state_q <= SVWait2;
        end
        SVWait2: begin
          if (div_done) begin
            vel_y_q <= neg_y_q ? 32'(-(div_quo[63:31] != '0 ? 32'h7FFFFFFF : div_quo[31:0]))
                               : (div_quo[63:31] != '0 ? 32'h7FFFFFFF : div_quo[31:0]);
            mv_q    <= motion_q;
            state_q <= SOut;
          end
        end
        STick: begin
          mv_q    <= 1'b0;
          state_q <= SOut;
          if (motion_q) begin
            if (pmt_pkg::passed(pos_x_q, vel_x_q, goal_x_q) &&
                pmt_pkg::passed(pos_y_q, vel_y_q, goal_y_q)) begin
              motion_q <= 1'b0;
              pos_x_q  <= goal_x_q;
              pos_y_q  <= goal_y_q;
            end else begin
              state_q <= STMulX;
            end
          end
        end
        STMulX: begin
          state_q <= STAdvX;
        end
        STAdvX: begin
          pos_x_q <= advance(pos_x_q, vel_x_q, mul_q);
          state_q <= STAdvY;
        end
        STAdvY: begin
          pos_y_q <= advance(pos_y_q, vel_y_q, mul_q);
          state_q <= STSnap;
        end
        STSnap: begin
          if (pmt_pkg::passed(pos_x_q, vel_x_q, goal_x_q)) begin
            pos_x_q <= goal_x_q;
            vel_x_q <= '0;
          end
          if (pmt_pkg::passed(pos_y_q, vel_y_q, goal_y_q)) begin
            pos_y_q <= goal_y_q;
            vel_y_q <= '0;
          end
          mv_q    <= 1'b1;
          state_q <= SOut;
        end
        SOut: begin
          if (out_ready_i) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign cur_x_o     = pos_x_q;
  assign cur_y_o     = pos_y_q;
  assign moving_o    = mv_q;

  `PMT_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o))
  `PMT_ASSERT_MSG(a_moving_needs_motion, out_valid_o && moving_o |-> motion_q,
                  "moving reported while stopped")
  `PMT_ASSERT_MSG(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o,
                  "ready right after an accepted beat")

endmodule

// File: tb/point_move_to_target_tb.sv
`timescale 1ns / 1ps

module point_move_to_target_tb;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned NumRandom = 1880;
  localparam longint unsigned CycleLimit = 3000000;
  localparam longint unsigned Sat31 = 64'h7FFF_FFFF;
  localparam longint unsigned Sat32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [31:0]        spd;
    logic signed [31:0] tm;
    logic [31:0]        tk;
  } move_cmd_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               mv;
  } point_t;

  typedef struct {
    move_cmd_t c;
    bit        typed;
    point_t    e;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         command_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] target_x_i;
  logic signed [31:0] target_y_i;
  logic [31:0]        move_speed_i;
  logic signed [31:0] move_time_i;
  logic [31:0]        tick_time_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] cur_x_o;
  logic signed [31:0] cur_y_o;
  logic               moving_o;

  point_move_to_target u_top (.*);

  // Model state of the mover.
  longint          at_x, at_y, goal_x, goal_y, vel_x, vel_y;
  longint unsigned speed_q;
  bit              motion_q;

  point_t          expected_points[$];
  int              errors;
  longint unsigned cycles;
  int              ready_pct;
  int              ready_hold;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned span(longint a, longint b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic longint unsigned norm_to_goal(output longint unsigned hs,
                                                   output longint unsigned vs,
                                                   output int sh);
    longint unsigned h, v;
    h  = span(goal_x, at_x);
    v  = span(goal_y, at_y);
    sh = ((h | v) >> 31) != 0 ? 1 : 0;
    hs = h >> sh;
    vs = v >> sh;
    return int_sqrt(hs * hs + vs * vs);
  endfunction

  function automatic void aim_velocity();
    longint unsigned hs, vs, d, mx, my;
    int sh;
    d = norm_to_goal(hs, vs, sh);
    if (vs != 0) begin
      mx = (speed_q * hs) / d;
      my = (speed_q * vs) / d;
      if (mx > Sat31) mx = Sat31;
      if (my > Sat31) my = Sat31;
      vel_x = (at_x > goal_x) ? -longint'(mx) : longint'(mx);
      vel_y = (at_y > goal_y) ? -longint'(my) : longint'(my);
    end else begin
      mx = speed_q;
      if (mx > Sat31) mx = Sat31;
      vel_x = (at_x > goal_x) ? -longint'(mx) : longint'(mx);
      vel_y = 0;
    end
  endfunction

  function automatic longint unsigned speed_for_time(longint t);
    longint unsigned hs, vs, gap_len, s;
    int sh;
    gap_len = norm_to_goal(hs, vs, sh) << sh;
    if (t == 0) return Sat32;
    s = (gap_len << pmt_pkg::FRAC_BITS) / longint'(t);
    if (s > Sat32) s = Sat32;
    if (s < (64'd1 << pmt_pkg::FRAC_BITS)) s = 64'd1 << pmt_pkg::FRAC_BITS;
    return s;
  endfunction

  function automatic bit reached(longint p, longint v, longint g);
    if (v > 0) return p + v >= g;
    return p + v <= g;
  endfunction

  function automatic longint step_axis(longint p, longint v, longint unsigned t);
    longint unsigned mag;
    longint r;
    mag = longint'((v < 0) ? -v : v) * t;
    r = (v < 0) ? p - longint'(mag >> pmt_pkg::FRAC_BITS)
                : p + longint'(mag >> pmt_pkg::FRAC_BITS);
    if (r > longint'(Sat31)) r = longint'(Sat31);
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic point_t apply_move(move_cmd_t c);
    point_t r;
    longint t;
    bit mv;
    t = c.tm;
    case (c.cmd)
      pmt_pkg::CmdSetPos: begin
        at_x = c.px; at_y = c.py; goal_x = c.px; goal_y = c.py;
        motion_q = 1'b0;
      end
      pmt_pkg::CmdSetSpeed: begin
        speed_q = c.spd;
        aim_velocity();
      end
      pmt_pkg::CmdStart: begin
        at_x = c.px; at_y = c.py; goal_x = c.tx; goal_y = c.ty;
        speed_q = c.spd;
        aim_velocity();
        motion_q = 1'b1;
      end
      pmt_pkg::CmdRetarget: begin
        if (c.spd != 0) speed_q = c.spd;
        goal_x = c.tx; goal_y = c.ty;
        aim_velocity();
        motion_q = 1'b1;
      end
      pmt_pkg::CmdRetTimed: begin
        if (t < 0) t = 64'sd1 << pmt_pkg::FRAC_BITS;
        goal_x = c.tx; goal_y = c.ty;
        speed_q = speed_for_time(t);
        aim_velocity();
        motion_q = 1'b1;
      end
      pmt_pkg::CmdStartTimed: begin
        at_x = c.px; at_y = c.py; goal_x = c.tx; goal_y = c.ty;
        speed_q = (t < 0) ? (64'd1 << pmt_pkg::FRAC_BITS) : speed_for_time(t);
        aim_velocity();
        motion_q = 1'b1;
      end
      default: ;
    endcase
    mv = motion_q;
    if (c.cmd == pmt_pkg::CmdTick) begin
      mv = 1'b0;
      if (motion_q) begin
        if (reached(at_x, vel_x, goal_x) && reached(at_y, vel_y, goal_y)) begin
          motion_q = 1'b0;
          at_x = goal_x;
          at_y = goal_y;
        end else begin
          at_x = step_axis(at_x, vel_x, c.tk);
          at_y = step_axis(at_y, vel_y, c.tk);
          if (reached(at_x, vel_x, goal_x)) begin
            at_x = goal_x;
            vel_x = 0;
          end
          if (reached(at_y, vel_y, goal_y)) begin
            at_y = goal_y;
            vel_y = 0;
          end
          mv = 1'b1;
        end
      end
    end
    r.x  = at_x[31:0];
    r.y  = at_y[31:0];
    r.mv = mv;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] small_rate();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  function automatic move_cmd_t any_cmd(logic [2:0] cmd);
    move_cmd_t c;
    c.cmd = cmd;
    c.px  = coord();
    c.py  = coord();
    c.tx  = coord();
    c.ty  = coord();
    c.spd = ($urandom_range(0, 5) == 0) ? 32'd0 : small_rate();
    c.tm  = ($urandom_range(0, 7) == 0) ? $urandom() :
            ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, 32'h0040_0000);
    c.tk  = small_rate();
    return c;
  endfunction

  task automatic send_cmd(move_cmd_t c, bit typed, point_t e);
    int gap;
    point_t p;
    int r;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= c.cmd;
    pos_x_i      <= c.px;
    pos_y_i      <= c.py;
    target_x_i   <= c.tx;
    target_y_i   <= c.ty;
    move_speed_i <= c.spd;
    move_time_i  <= c.tm;
    tick_time_i  <= c.tk;
    do @(posedge clk_i); while (!in_ready_o);
    p = apply_move(c);
    expected_points.push_back(typed ? e : p);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[point_move_to_target] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 30;
        default: ready_pct = ($urandom_range(0, 3) == 0) ? 2 : 90;
      endcase
      ready_hold = $urandom_range(20, 300);
    end else begin
      ready_hold--;
    end
    out_ready_i <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected beat", cur_x_o, 0);
      end else begin
        e = expected_points.pop_front();
        if (cur_x_o !== e.x) report_mismatch("cur_x", cur_x_o, e.x);
        if (cur_y_o !== e.y) report_mismatch("cur_y", cur_y_o, e.y);
        if (moving_o !== e.mv) report_mismatch("moving", moving_o, e.mv);
      end
    end
  end

  row_t rows [25] = '{
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0001_0000}, 1'b1, '{0, 0, 1'b0}},
    '{'{CmdUnused, 5, 6, 7, 8, 9, 10, 11}, 1'b1, '{0, 0, 1'b0}},
    '{'{pmt_pkg::CmdSetPos, 32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 3, 4, 5}, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
    '{'{pmt_pkg::CmdSetPos, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0}, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
    '{'{pmt_pkg::CmdStart, 0, 0, 32'h000A_0000, 0, 32'h0001_0000, 0, 0}, 1'b0,
      '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0001_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0008_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0001_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0001_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdStart, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'hFFFF_FFFF, 0, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdSetSpeed, 0, 0, 0, 0, 32'h0002_0000, 0, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdRetarget, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdRetTimed, 0, 0, 32'h0064_0000, 32'hFFCE_0000, 0, 32'h8000_0000, 0},
      1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdRetTimed, 0, 0, 32'h0010_0000, 32'h0020_0000, 0, 0, 0}, 1'b0,
      '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0000_0100}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdStartTimed, 32'h0001_0000, 32'h0002_0000, 32'hFFF0_0000,
        32'h0003_0000, 0, 32'hFFFF_FFFF, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdStartTimed, 0, 0, 32'h0005_0000, 32'h0005_0000, 0, 0, 0}, 1'b0,
      '{0, 0, 0}},
    '{'{pmt_pkg::CmdStartTimed, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 32'h0004_0000,
        0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0002_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0002_0000}, 1'b0, '{0, 0, 0}},
    '{'{CmdUnused, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdStart, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
        32'h0001_0000, 0, 0}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdTick, 0, 0, 0, 0, 0, 0, 32'h0001_0000}, 1'b0, '{0, 0, 0}},
    '{'{pmt_pkg::CmdSetPos, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b0}}
  };

  initial begin
    move_cmd_t c;
    point_t none;
    int sent;
    int ticks;
    bit paused;
    errors       = 0;
    cycles       = 0;
    ready_pct    = 100;
    ready_hold   = 0;
    none         = '{0, 0, 1'b0};
    at_x = 0; at_y = 0; goal_x = 0; goal_y = 0; vel_x = 0; vel_y = 0;
    speed_q      = 0;
    motion_q     = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    command_i    = pmt_pkg::CmdSetPos;
    pos_x_i      = '0;
    pos_y_i      = '0;
    target_x_i   = '0;
    target_y_i   = '0;
    move_speed_i = '0;
    move_time_i  = '0;
    tick_time_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].e);

    sent   = 0;
    paused = 1'b0;
    while (sent < NumRandom) begin
      if (!paused && sent > NumRandom / 2) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) < 7) begin
        c = any_cmd($urandom_range(0, 9) < 6 ? pmt_pkg::CmdStart : pmt_pkg::CmdStartTimed);
        if ($urandom_range(0, 3) == 0) begin
          c.cmd = $urandom_range(0, 1) ? pmt_pkg::CmdRetarget : pmt_pkg::CmdRetTimed;
        end
        send_cmd(c, 1'b0, none);
        sent++;
        ticks = $urandom_range(1, 10);
        for (int k = 0; k < ticks; k++) begin
          c = any_cmd(pmt_pkg::CmdTick);
          if ($urandom_range(0, 9) == 0) c.cmd = pmt_pkg::CmdSetSpeed;
          send_cmd(c, 1'b0, none);
          sent++;
        end
      end else begin
        send_cmd(any_cmd(3'($urandom_range(0, 7))), 1'b0, none);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("[point_move_to_target] OK");
    end else begin
      $display("[point_move_to_target] ERROR");
    end
    $finish;
  end

endmodule
